// ----- rtl/esph_pkg.sv -----
package esph_pkg;

	// Default channel count per frame
	localparam int CHANNELS_DEF = 128;

	// Field widths
	localparam int COUNT_W     = 8;
	localparam int LEVEL_W     = 16;
	localparam int CHAN_W      = 7;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;

	// Serial step counter covers one level word
	localparam int STEP_W = $clog2(LEVEL_W);

	typedef logic [LEVEL_W-1:0] level_t;
	typedef logic [COUNT_W-1:0] count_t;

	// Configuration register indexes
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_SCAN_PASSES = 3'd0,
		REG_ATTACK_GAIN = 3'd1,
		REG_DECAY_GAIN  = 3'd2,
		REG_BLEED_GAIN  = 3'd3
	} cfg_reg_t;

	// Register reset values (Q0.16 gains: 0.6, 0.12, 0.02)
	localparam count_t SCAN_PASSES_RST = 8'd1;
	localparam level_t ATTACK_GAIN_RST = 16'd39322;
	localparam level_t DECAY_GAIN_RST  = 16'd7864;
	localparam level_t BLEED_GAIN_RST  = 16'd1311;

	// Full scale target
	localparam level_t LEVEL_FULL = 16'hFFFF;

endpackage

// ----- rtl/esph_div.sv -----
// Restoring divider, one quotient bit per cycle: quotient = (dividend << 16) / divisor.
// Valid only for dividend < divisor; other cases are handled by the caller.
module esph_div (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  esph_pkg::count_t       dividend,
	input  esph_pkg::count_t       divisor,
	output logic                   done,
	output esph_pkg::level_t       quotient
);

	logic [esph_pkg::COUNT_W-1:0] rem_q;
	esph_pkg::level_t             quo_q;
	logic [esph_pkg::STEP_W-1:0]  step_q;
	logic                         busy_q;
	logic                         done_q;

	logic [esph_pkg::COUNT_W:0]   rem_sh;
	logic                         ge;
	logic [esph_pkg::COUNT_W-1:0] rem_nx;

	// One trial subtraction per step
	always_comb begin
		rem_sh = {rem_q, 1'b0};
		ge     = (rem_sh >= {1'b0, divisor});
		rem_nx = ge ? esph_pkg::COUNT_W'(rem_sh - {1'b0, divisor})
		            : rem_sh[esph_pkg::COUNT_W-1:0];
	end

	// Step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == esph_pkg::STEP_W'(esph_pkg::LEVEL_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and quotient shift registers
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= rem_nx;
			quo_q <= {quo_q[esph_pkg::LEVEL_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ----- rtl/esph_mul.sv -----
// Shift-add multiplier, one gain bit per cycle: product = (multiplicand * gain) >> 16.
module esph_mul (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  esph_pkg::level_t multiplicand,
	input  esph_pkg::level_t gain,
	output logic             done,
	output esph_pkg::level_t product
);

	esph_pkg::level_t            acc_q;
	esph_pkg::level_t            mcand_q;
	esph_pkg::level_t            gain_q;
	logic [esph_pkg::STEP_W-1:0] step_q;
	logic                        busy_q;
	logic                        done_q;

	logic [esph_pkg::LEVEL_W:0]  sum;

	// Add partial product, then drop the low bit
	always_comb begin
		sum = {1'b0, acc_q} + (gain_q[0] ? {1'b0, mcand_q} : '0);
	end

	// Step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == esph_pkg::STEP_W'(esph_pkg::LEVEL_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Accumulator and gain shift register
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q   <= '0;
			mcand_q <= multiplicand;
			gain_q  <= gain;
		end else if (busy_q) begin
			acc_q  <= sum[esph_pkg::LEVEL_W:1];
			gain_q <= gain_q >> 1;
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule

// ----- rtl/spectrum_envelope_peak_hold.sv -----
// Envelope follower with peak hold over a frame of CHANNELS spectrum bins, one hit
// count per request in channel order. Each request keeps in_stall high from its
// acceptance until the block returns to idle, so no new request is accepted while one
// is in progress. A request passes through the bit-serial divider that normalizes the
// count by scan_passes, a state that picks the gain, the two bit-serial multipliers
// (smoothing and bleed, run side by side), and a final state that writes back and loads
// the output register, before the block is idle again and accepts the next request. A
// result waiting on out_stall holds the block in its final state only if the output
// register is still full. Levels are unsigned Q0.16; during the first frame after reset
// both levels load the normalized count directly. Registers are to be written only
// while idle; the block itself does not enforce this.
module spectrum_envelope_peak_hold #(
	parameter int CHANNELS = esph_pkg::CHANNELS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Configuration
	input  logic                                cfg_we,
	input  logic [esph_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [esph_pkg::CFG_DATA_W-1:0]     cfg_data,
	// Input channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [esph_pkg::COUNT_W-1:0]        bin_count,
	// Output channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [esph_pkg::CHAN_W-1:0]         channel,
	output logic [esph_pkg::LEVEL_W-1:0]        smooth_level,
	output logic [esph_pkg::LEVEL_W-1:0]        hold_level,
	output logic                                last_of_frame
);

	localparam int PW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_DIV  = 5'b00010,
		ST_PREP = 5'b00100,
		ST_MUL  = 5'b01000,
		ST_FIN  = 5'b10000
	} state_t;

	state_t                state_q;

	// Configuration registers
	esph_pkg::count_t      scan_passes_q;
	esph_pkg::level_t      attack_gain_q;
	esph_pkg::level_t      decay_gain_q;
	esph_pkg::level_t      bleed_gain_q;

	// Frame position
	logic [PW-1:0]         pos_q;
	logic                  primed_q;

	// Per-request working registers
	logic                  zero_q;
	logic                  sat_q;
	esph_pkg::level_t      smooth_rd_q;
	esph_pkg::level_t      hold_rd_q;
	esph_pkg::level_t      target_q;
	logic                  rise_q;
	logic                  hit_q;

	// Level stores
	esph_pkg::level_t      smooth_mem [CHANNELS];
	esph_pkg::level_t      hold_mem   [CHANNELS];

	// Output register
	logic                  out_valid_q;
	logic [esph_pkg::CHAN_W-1:0]  channel_q;
	esph_pkg::level_t      smooth_out_q;
	esph_pkg::level_t      hold_out_q;
	logic                  last_q;

	logic                  in_acc;
	logic                  fin_go;
	logic                  div_done;
	esph_pkg::level_t      quotient;
	esph_pkg::level_t      target;
	logic                  rise;
	esph_pkg::level_t      diff;
	esph_pkg::level_t      step_gain;
	logic                  mul_s_done;
	logic                  mul_h_done;
	esph_pkg::level_t      smooth_delta;
	esph_pkg::level_t      bleed_delta;
	esph_pkg::level_t      smooth_new;
	esph_pkg::level_t      hold_new;
	logic                  last;
	logic [PW+esph_pkg::CHAN_W-1:0] pos_ext;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && (state_q == ST_IDLE);
	assign fin_go   = (state_q == ST_FIN) && (!out_valid_q || !out_stall);
	assign last     = (pos_q == PW'(CHANNELS - 1));
	assign pos_ext  = {{esph_pkg::CHAN_W{1'b0}}, pos_q};

	// Configuration write decoder
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_passes_q <= esph_pkg::SCAN_PASSES_RST;
			attack_gain_q <= esph_pkg::ATTACK_GAIN_RST;
			decay_gain_q  <= esph_pkg::DECAY_GAIN_RST;
			bleed_gain_q  <= esph_pkg::BLEED_GAIN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				esph_pkg::REG_SCAN_PASSES: scan_passes_q <= cfg_data[esph_pkg::COUNT_W-1:0];
				esph_pkg::REG_ATTACK_GAIN: attack_gain_q <= cfg_data;
				esph_pkg::REG_DECAY_GAIN:  decay_gain_q  <= cfg_data;
				esph_pkg::REG_BLEED_GAIN:  bleed_gain_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Normalizing divider
	esph_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (in_acc),
		.dividend (bin_count),
		.divisor  (scan_passes_q),
		.done     (div_done),
		.quotient (quotient)
	);

	// Target with zero-divisor and saturation cases, then gain selection
	always_comb begin
		if (zero_q)
			target = '0;
		else if (sat_q)
			target = esph_pkg::LEVEL_FULL;
		else
			target = quotient;
		rise      = (target > smooth_rd_q);
		diff      = rise ? (target - smooth_rd_q) : (smooth_rd_q - target);
		step_gain = rise ? attack_gain_q : decay_gain_q;
	end

	// Smoothing and bleed multipliers
	esph_mul u_mul_smooth (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (state_q == ST_PREP),
		.multiplicand (diff),
		.gain         (step_gain),
		.done         (mul_s_done),
		.product      (smooth_delta)
	);

	esph_mul u_mul_bleed (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (state_q == ST_PREP),
		.multiplicand (hold_rd_q),
		.gain         (bleed_gain_q),
		.done         (mul_h_done),
		.product      (bleed_delta)
	);

	// Level update
	always_comb begin
		if (!primed_q) begin
			smooth_new = target_q;
			hold_new   = target_q;
		end else begin
			smooth_new = rise_q ? (smooth_rd_q + smooth_delta) : (smooth_rd_q - smooth_delta);
			hold_new   = hit_q ? target_q : (hold_rd_q - bleed_delta);
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			pos_q    <= '0;
			primed_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (in_acc) state_q <= ST_DIV;
				ST_DIV:  if (div_done) state_q <= ST_PREP;
				ST_PREP: state_q <= ST_MUL;
				ST_MUL:  if (mul_s_done && mul_h_done) state_q <= ST_FIN;
				ST_FIN: begin
					if (fin_go) begin
						state_q <= ST_IDLE;
						if (last) begin
							pos_q    <= '0;
							primed_q <= 1'b1;
						end else begin
							pos_q <= pos_q + 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Request working registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			zero_q <= (scan_passes_q == '0);
			sat_q  <= (bin_count >= scan_passes_q);
		end
		if (state_q == ST_PREP) begin
			target_q <= target;
			rise_q   <= rise;
			hit_q    <= (target > hold_rd_q);
		end
	end

	// Level stores: read on accept, write back on completion
	always_ff @(posedge clk) begin
		if (in_acc) begin
			smooth_rd_q <= smooth_mem[pos_q];
			hold_rd_q   <= hold_mem[pos_q];
		end
		if (fin_go) begin
			smooth_mem[pos_q] <= smooth_new;
			hold_mem[pos_q]   <= hold_new;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			channel_q    <= pos_ext[esph_pkg::CHAN_W-1:0];
			smooth_out_q <= smooth_new;
			hold_out_q   <= hold_new;
			last_q       <= last;
		end
	end

	assign out_valid     = out_valid_q;
	assign channel       = channel_q;
	assign smooth_level  = smooth_out_q;
	assign hold_level    = hold_out_q;
	assign last_of_frame = last_q;

endmodule

// ----- rtl/esph_checker.sv -----
module esph_checker #(
	parameter int CHANNELS = esph_pkg::CHANNELS_DEF
) (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_stall,
	input logic                                out_valid,
	input logic                                out_stall,
	input logic [esph_pkg::CHAN_W-1:0]         channel,
	input logic [esph_pkg::LEVEL_W-1:0]        smooth_level,
	input logic [esph_pkg::LEVEL_W-1:0]        hold_level,
	input logic                                last_of_frame
);

	// A stalled result stays and keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(channel)
			&& $stable(smooth_level) && $stable(hold_level) && $stable(last_of_frame))
		else $error("stalled result changed");

	// One request at a time: busy right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request accepted while busy");

	// Frame end only on the last channel
	a_last_channel: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_of_frame |-> channel == esph_pkg::CHAN_W'(CHANNELS - 1))
		else $error("frame end on wrong channel");

	// No result appears in the cycle after an accept from idle
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !out_valid |=> !out_valid)
		else $error("result appeared too early");

endmodule

bind spectrum_envelope_peak_hold esph_checker #(.CHANNELS(CHANNELS)) u_esph_checker (.*);

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
	import esph_pkg::*;

	localparam int CHANNELS      = CHANNELS_DEF;
	localparam int RANDOM_PHASES = 16;
	localparam int PHASE_ITEMS   = 62;
	localparam int TAIL_CYCLES   = 40;
	localparam int MAX_REPORTS   = 30;

	// Indexes outside the register map, writes there must be ignored
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

	typedef struct {
		logic [CHAN_W-1:0] chan;
		level_t            smooth;
		level_t            hold;
		logic              last;
	} envelope_result_t;

	// Envelope/peak-hold predictor plus queue of expected channel results
	class envelope_scoreboard;
		count_t           passes;
		level_t           attack;
		level_t           decay;
		level_t           bleed;
		level_t           smooth_mem [CHANNELS];
		level_t           hold_mem   [CHANNELS];
		bit               primed;
		int unsigned      pos;
		envelope_result_t levels_q[$];
		int               errors;
		int               requests;
		int               checked;

		function new();
			passes   = SCAN_PASSES_RST;
			attack   = ATTACK_GAIN_RST;
			decay    = DECAY_GAIN_RST;
			bleed    = BLEED_GAIN_RST;
			primed   = 0;
			pos      = 0;
			errors   = 0;
			requests = 0;
			checked  = 0;
			foreach (smooth_mem[i]) begin
				smooth_mem[i] = '0;
				hold_mem[i]   = '0;
			end
		endfunction

		function int pending();
			return levels_q.size();
		endfunction

		task report_mismatch(string msg);
			if (errors < MAX_REPORTS)
				$display("[%0t] MISMATCH: %s", $time, msg);
			errors++;
		endtask

		function void note_config(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_SCAN_PASSES: passes = data[COUNT_W-1:0];
				REG_ATTACK_GAIN: attack = data;
				REG_DECAY_GAIN:  decay  = data;
				REG_BLEED_GAIN:  bleed  = data;
				default: ;
			endcase
		endfunction

		// count / passes in Q0.16, clamped to full scale
		function level_t norm_target(count_t cnt);
			logic [23:0] num;
			if (passes == 0)
				return '0;
			if (cnt >= passes)
				return LEVEL_FULL;
			num = {cnt, 16'h0000};
			return level_t'(num / passes);
		endfunction

		function void note_request(count_t cnt);
			logic [31:0]      t;
			logic [31:0]      s;
			logic [31:0]      h;
			envelope_result_t r;
			t = norm_target(cnt);
			s = smooth_mem[pos];
			h = hold_mem[pos];
			if (!primed) begin
				s = t;
				h = t;
			end else begin
				// attack gain on a rise, decay gain on a fall; products truncated
				if (t > s)
					s = s + (((t - s) * attack) >> 16);
				else
					s = s - (((s - t) * decay) >> 16);
				// peak jumps up, otherwise bleeds a fraction of itself
				if (t > h)
					h = t;
				else
					h = h - ((h * bleed) >> 16);
			end
			smooth_mem[pos] = s[LEVEL_W-1:0];
			hold_mem[pos]   = h[LEVEL_W-1:0];
			r.chan   = CHAN_W'(pos);
			r.smooth = s[LEVEL_W-1:0];
			r.hold   = h[LEVEL_W-1:0];
			r.last   = (pos == CHANNELS - 1);
			levels_q.push_back(r);
			if (r.last) begin
				primed = 1;
				pos    = 0;
			end else begin
				pos++;
			end
			requests++;
		endfunction

		task check_result(logic [CHAN_W-1:0] chan, level_t smooth, level_t hold, logic last);
			envelope_result_t r;
			if (levels_q.size() == 0) begin
				report_mismatch($sformatf("unexpected result ch=%0d", chan));
				return;
			end
			r = levels_q.pop_front();
			checked++;
			if (chan !== r.chan)
				report_mismatch($sformatf("channel got %0d exp %0d", chan, r.chan));
			if (smooth !== r.smooth)
				report_mismatch($sformatf("ch %0d smooth_level got %0d exp %0d",
					r.chan, smooth, r.smooth));
			if (hold !== r.hold)
				report_mismatch($sformatf("ch %0d hold_level got %0d exp %0d",
					r.chan, hold, r.hold));
			if (last !== r.last)
				report_mismatch($sformatf("ch %0d last_of_frame got %0b exp %0b",
					r.chan, last, r.last));
		endtask
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	logic                   in_valid;
	logic                   in_stall;
	count_t                 bin_count;
	logic                   out_valid;
	logic                   out_stall;
	logic [CHAN_W-1:0]      channel;
	level_t                 smooth_level;
	level_t                 hold_level;
	logic                   last_of_frame;

	envelope_scoreboard sb;
	int tx_idle_pct  = 0;
	int rx_stall_pct = 0;

	always #5 clk = ~clk;

	spectrum_envelope_peak_hold #(
		.CHANNELS(CHANNELS)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.bin_count    (bin_count),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.channel      (channel),
		.smooth_level (smooth_level),
		.hold_level   (hold_level),
		.last_of_frame(last_of_frame)
	);

	// Register write, one per clock; caller drops cfg_we after a batch
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		sb.note_config(idx, data);
	endtask

	// Present one count request, with an optional idle gap first
	task automatic send_count(input count_t cnt);
		if ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 60)) @(posedge clk);
		end
		in_valid  <= 1'b1;
		bin_count <= cnt;
		do @(posedge clk); while (in_stall);
		sb.note_request(cnt);
	endtask

	// Drop valid and wait for every outstanding result
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	function automatic level_t pick_gain();
		int unsigned sel;
		sel = $urandom_range(0, 7);
		if (sel == 0)
			return '0;
		if (sel == 1)
			return LEVEL_FULL;
		return level_t'($urandom_range(0, 65535));
	endfunction

	function automatic count_t pick_passes();
		int unsigned sel;
		sel = $urandom_range(0, 9);
		if (sel == 0)
			return '0;
		if (sel == 1)
			return 8'd1;
		if (sel == 2)
			return 8'd255;
		return count_t'($urandom_range(1, 255));
	endfunction

	// Mostly counts within the pass count, some near the clamp, some anywhere
	function automatic count_t pick_count(input count_t passes);
		int unsigned sel;
		int          near;
		sel = $urandom_range(0, 9);
		if (passes != 0 && sel < 6)
			return count_t'($urandom_range(0, passes));
		if (passes != 0 && sel < 8) begin
			near = int'(passes) - 1 + int'($urandom_range(0, 2));
			return count_t'((near > 255) ? 255 : near);
		end
		return count_t'($urandom_range(0, 255));
	endfunction

	// Result sink: checks accepted results, stalls in random runs
	initial begin : result_sink
		int run_left;
		bit stall_now;
		run_left  = 0;
		stall_now = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall)
				sb.check_result(channel, smooth_level, hold_level, last_of_frame);
			if (run_left == 0) begin
				stall_now = ($urandom_range(0, 99) < rx_stall_pct);
				run_left  = $urandom_range(1, 24);
			end
			run_left--;
			out_stall <= stall_now;
		end
	end

	initial begin : stimulus
		count_t passes;
		level_t ga;
		level_t gd;
		level_t gb;
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		in_valid  <= 1'b0;
		bin_count <= '0;
		sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: writes to unmapped indexes change nothing
		write_reg(REG_SPARE_LO, 16'hFFFF);
		write_reg(REG_SPARE_HI, 16'h0000);
		cfg_we <= 1'b0;
		// first frame loads both levels; reset pass count of one
		send_count(8'd0);
		send_count(8'd255);
		send_count(8'd1);
		send_count(8'd0);
		drain();
		// zero pass count: every target is zero
		write_reg(REG_SCAN_PASSES, 16'h0000);
		cfg_we <= 1'b0;
		send_count(8'd255);
		send_count(8'd128);
		send_count(8'd0);
		drain();
		// widest pass count, junk in the upper data bits
		write_reg(REG_SCAN_PASSES, 16'hA5FF);
		cfg_we <= 1'b0;
		send_count(8'd0);
		send_count(8'd1);
		send_count(8'd127);
		send_count(8'd128);
		send_count(8'd254);
		send_count(8'd255);
		drain();
		// odd divisor, counts above it clamp to full scale
		write_reg(REG_SCAN_PASSES, 16'h5A03);
		cfg_we <= 1'b0;
		send_count(8'd1);
		send_count(8'd2);
		send_count(8'd3);
		send_count(8'd4);
		send_count(8'd200);
		drain();

		// Random phases, each with its own settings and idling mode
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph)
				1: begin
					passes = 8'd255;
					ga = LEVEL_FULL;
					gd = LEVEL_FULL;
					gb = LEVEL_FULL;
				end
				2: begin
					passes = 8'd1;
					ga = '0;
					gd = '0;
					gb = '0;
				end
				default: begin
					passes = pick_passes();
					ga = pick_gain();
					gd = pick_gain();
					gb = pick_gain();
				end
			endcase
			write_reg(REG_SCAN_PASSES, {8'($urandom), passes});
			write_reg(REG_ATTACK_GAIN, ga);
			write_reg(REG_DECAY_GAIN, gd);
			write_reg(REG_BLEED_GAIN, gb);
			if ($urandom_range(0, 3) == 0)
				write_reg(REG_SPARE_LO + CFG_INDEX_W'($urandom_range(0, 3)), 16'($urandom));
			cfg_we <= 1'b0;
			case (ph % 4)
				0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
				1: begin tx_idle_pct = 57; rx_stall_pct = 0;  end
				2: begin tx_idle_pct = 0;  rx_stall_pct = 57; end
				default: begin tx_idle_pct = 12; rx_stall_pct = 12; end
			endcase
			repeat (PHASE_ITEMS) send_count(pick_count(passes));
			drain();
		end

		// Tail: anything arriving now is unexpected
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.pending() != 0)
			sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));

		$display("Ran %0d count requests over %0d register settings, %0d results checked",
			sb.requests, RANDOM_PHASES + 4, sb.checked);
		$display("Mixed sender gaps and receiver stalls, gains at both extremes, zero pass count");
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Hard limit on simulated time
	initial begin : watchdog
		#10000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
